// File: hdl/wurt_pkg.sv
// shared types and constants of the windowed usage rise tracker
// no dependencies; used by the channel interfaces and the top level

package wurt_pkg;

	// bucket ring and time slots
	localparam int NUM_BUCKETS  = 6;
	localparam int SLOT_SECONDS = 300;
	localparam int REPORTED     = 6;

	// field widths
	localparam int TIME_W   = 32;
	localparam int LEVEL_W  = 15;
	localparam int LVL_W    = 14;
	localparam int TOL_W    = 10;
	localparam int STATUS_W = 3;
	localparam int CNT_W    = 16;
	localparam int TAG_W    = 24;
	localparam int RISE_W   = 16;
	localparam int TOTAL_W  = 19;
	localparam int MEM_W    = TAG_W + RISE_W;

	// derived widths
	localparam int IDX_W   = $clog2(NUM_BUCKETS);
	localparam int HIT_W   = $clog2(NUM_BUCKETS + 1);
	localparam int RPT_W   = $clog2(REPORTED);
	localparam int POS_W   = (HIT_W > RPT_W) ? HIT_W : RPT_W;
	localparam int SLOT_SW = $clog2(SLOT_SECONDS + 1);

	// slot = now / SLOT_SECONDS by reciprocal, off by at most one low
	localparam int SLOT_SH = TIME_W + $clog2(SLOT_SECONDS);
	localparam logic [TIME_W:0] SLOT_RECIP =
		(TIME_W + 1)'((65'd1 << SLOT_SH) / SLOT_SECONDS);
	localparam int P1_W = 2 * TIME_W + 1;
	localparam int M1_W = TIME_W + SLOT_SW;

	// idx = slot % NUM_BUCKETS by reciprocal, same correction
	localparam int MOD_SH = TIME_W + $clog2(NUM_BUCKETS);
	localparam logic [TIME_W:0] MOD_RECIP =
		(TIME_W + 1)'((65'd1 << MOD_SH) / NUM_BUCKETS);
	localparam int M2_W = TIME_W + HIT_W;
	localparam int R2_W = HIT_W + 1;

	// register reset values
	localparam logic [TIME_W-1:0] MIN_VALID_RESET = 32'd1700000000;
	localparam logic [TOL_W-1:0]  TOL_RESET       = 10'd5;

	localparam int ADDR_W = 3;

	typedef enum logic {
		REG_MIN_VALID_TIME  = 1'b0,
		REG_RESET_TOLERANCE = 1'b1
	} cfg_reg_t;

	typedef enum logic [STATUS_W-1:0] {
		SC_CLOCK_WAIT    = 3'd0,
		SC_LEVEL_MISSING = 3'd1,
		SC_RESET_SEEN    = 3'd2,
		SC_BASELINE      = 3'd3,
		SC_ONLINE_FULL   = 3'd4,
		SC_ONLINE_PART   = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_MUL,
		ST_DIV_FIX,
		ST_SLOT,
		ST_MOD_MUL,
		ST_MOD_FIX,
		ST_IDX,
		ST_RMW,
		ST_WALK,
		ST_DONE
	} state_t;

endpackage

// File: hdl/wurt_channels.sv
// valid/ready channel interfaces for samples and reports
// depends on wurt_pkg

interface wurt_sample_if import wurt_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [TIME_W-1:0]        now_seconds;
	logic signed [LEVEL_W-1:0] level_used;

	modport source (output valid, output now_seconds, output level_used, input ready);
	modport sink   (input valid, input now_seconds, input level_used, output ready);
endinterface

interface wurt_report_if import wurt_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status_code;
	logic                is_ready;
	logic [CNT_W-1:0]    samples_seen;
	logic [REPORTED-1:0] bucket_mask;
	logic [TOTAL_W-1:0]  window_total;
	logic [RISE_W-1:0]   rise_0;
	logic [RISE_W-1:0]   rise_1;
	logic [RISE_W-1:0]   rise_2;
	logic [RISE_W-1:0]   rise_3;
	logic [RISE_W-1:0]   rise_4;
	logic [RISE_W-1:0]   rise_5;

	modport source (
		output valid, output status_code, output is_ready, output samples_seen,
		output bucket_mask, output window_total,
		output rise_0, output rise_1, output rise_2, output rise_3, output rise_4, output rise_5,
		input ready
	);
	modport sink (
		input valid, input status_code, input is_ready, input samples_seen,
		input bucket_mask, input window_total,
		input rise_0, input rise_1, input rise_2, input rise_3, input rise_4, input rise_5,
		output ready
	);
endinterface

// File: hdl/windowed_usage_rise_tracker_unit.sv
// top level of the windowed usage rise tracker: sequencer, bucket memory, apb registers
// depends on wurt_pkg and the channel interfaces in wurt_channels.sv
//
//  channel   dir  handshake         payload
//  sample    in   valid/ready       now_seconds, level_used
//  report    out  valid/ready       status_code, is_ready, samples_seen, bucket_mask,
//                                   window_total, rise_0..rise_5
//  apb       in   psel/penable      paddr, pwdata, prdata (pready tied high)
//
// a sample with a usable time and level passes from transfer to report through
// six steps of slot and ring index arithmetic on the reciprocal multipliers,
// one read-modify-write of the current bucket, then one bucket memory read per
// window bucket. clock wait and missing level samples go straight from idle to
// the done state. one sample is in flight at a time; a finished report sits in
// the output register, so the next sample transfers while it waits. arst_n
// clears all control state and bucket valid bits at once.

module windowed_usage_rise_tracker_unit import wurt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	wurt_sample_if.sink         sample,
	wurt_report_if.source       report,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	// configuration registers
	logic [TIME_W-1:0] min_valid_q;
	logic [TOL_W-1:0]  tol_q;
	logic              cfg_wr;

	// sequencer
	state_t state_q, state_d;
	logic   out_free;
	logic   load_out;

	// captured sample
	logic [TIME_W-1:0] now_q;
	logic [LVL_W-1:0]  level_q;
	logic              early_q;
	status_t           early_code_q;

	// slot and index arithmetic
	logic [P1_W-1:0]   p1_q;
	logic [TIME_W-1:0] q1_q;
	logic [M1_W-1:0]   m1_q;
	logic [TIME_W-1:0] slot_q;
	logic [P1_W-1:0]   p2_q;
	logic [M2_W-1:0]   m2_q;
	logic [IDX_W-1:0]  idx_q;
	logic [TIME_W-1:0] q1;
	logic [M1_W-1:0]   r1;
	logic [TIME_W-1:0] q2;
	logic [R2_W-1:0]   r2;
	logic [IDX_W-1:0]  idx_d;

	// bucket memory (tag, rise) with valid bits in flops
	logic [MEM_W-1:0]       mem [NUM_BUCKETS];
	logic [MEM_W-1:0]       rd_q;
	logic [IDX_W-1:0]       rd_addr;
	logic [NUM_BUCKETS-1:0] bvalid_q;

	// tracking state
	logic [LVL_W-1:0] last_level_q;
	logic             last_valid_q;
	logic [CNT_W-1:0] samples_q;
	logic             reset_seen_q;

	// read-modify-write of the current bucket
	logic [TAG_W-1:0]       rd_tag;
	logic [RISE_W-1:0]      rd_rise;
	logic                   hit_cur;
	logic                   reset_now;
	logic [LVL_W-1:0]       delta;
	logic [RISE_W:0]        rise_sum;
	logic [RISE_W-1:0]      rise_new;
	logic [NUM_BUCKETS-1:0] cur_onehot;
	logic [TIME_W-1:0]      first_slot;
	logic [IDX_W-1:0]       first_ptr;

	// window walk
	logic [POS_W-1:0]    pos_q;
	logic [IDX_W-1:0]    ptr_q;
	logic [TIME_W-1:0]   want_q;
	logic                act_s1;
	logic                vld_s1;
	logic [TAG_W-1:0]    want_tag_s1;
	logic [POS_W-1:0]    pos_s1;
	logic                walk_hit;
	logic [TOTAL_W:0]    total_sum;
	logic [REPORTED-1:0] mask_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [HIT_W-1:0]    hits_q;
	logic [RISE_W-1:0]   rises_q [REPORTED];

	// output register
	logic                out_valid_q;
	status_t             status_q;
	logic                is_ready_q;
	logic [CNT_W-1:0]    seen_q;
	logic [REPORTED-1:0] omask_q;
	logic [TOTAL_W-1:0]  ototal_q;
	logic [RISE_W-1:0]   orise_q [REPORTED];
	status_t             status_d;

	// apb port: writes land on the access phase, reads are combinational
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		if (cfg_reg_t'(paddr[2]) == REG_RESET_TOLERANCE) begin
			prdata = {{(32 - TOL_W){1'b0}}, tol_q};
		end else begin
			prdata = min_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_valid_q <= MIN_VALID_RESET;
			tol_q       <= TOL_RESET;
		end else if (cfg_wr) begin
			if (cfg_reg_t'(paddr[2]) == REG_RESET_TOLERANCE) begin
				tol_q <= pwdata[TOL_W-1:0];
			end else begin
				min_valid_q <= pwdata[TIME_W-1:0];
			end
		end
	end

	// next state
	assign out_free = !out_valid_q || report.ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sample.valid) begin
					if ((sample.now_seconds < min_valid_q) || sample.level_used[LEVEL_W-1]) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_DIV_MUL;
					end
				end
			end
			ST_DIV_MUL: state_d = ST_DIV_FIX;
			ST_DIV_FIX: state_d = ST_SLOT;
			ST_SLOT:    state_d = ST_MOD_MUL;
			ST_MOD_MUL: state_d = ST_MOD_FIX;
			ST_MOD_FIX: state_d = ST_IDX;
			ST_IDX:     state_d = ST_RMW;
			ST_RMW:     state_d = ST_WALK;
			ST_WALK: begin
				if (pos_q == POS_W'(NUM_BUCKETS)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		sample.ready = (state_q == ST_IDLE);
		load_out     = (state_q == ST_DONE) && out_free;
		if (state_q == ST_IDX) begin
			rd_addr = idx_d;
		end else begin
			rd_addr = ptr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// slot and ring index: quotient estimate, then one compare and subtract
	always_comb begin
		q1 = TIME_W'(p1_q >> SLOT_SH);
		r1 = M1_W'(now_q) - m1_q;
		q2 = TIME_W'(p2_q >> MOD_SH);
		r2 = R2_W'(M2_W'(slot_q) - m2_q);
		if (r2 >= R2_W'(NUM_BUCKETS)) begin
			idx_d = IDX_W'(r2 - R2_W'(NUM_BUCKETS));
		end else begin
			idx_d = IDX_W'(r2);
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			now_q   <= sample.now_seconds;
			level_q <= sample.level_used[LVL_W-1:0];
			early_q <= (sample.now_seconds < min_valid_q) || sample.level_used[LEVEL_W-1];
			if (sample.now_seconds < min_valid_q) begin
				early_code_q <= SC_CLOCK_WAIT;
			end else begin
				early_code_q <= SC_LEVEL_MISSING;
			end
		end
		if (state_q == ST_DIV_MUL) begin
			p1_q <= P1_W'(now_q) * P1_W'(SLOT_RECIP);
		end
		if (state_q == ST_DIV_FIX) begin
			q1_q <= q1;
			m1_q <= M1_W'(q1) * M1_W'(SLOT_SECONDS);
		end
		if (state_q == ST_SLOT) begin
			if (r1 >= M1_W'(SLOT_SECONDS)) begin
				slot_q <= q1_q + TIME_W'(1);
			end else begin
				slot_q <= q1_q;
			end
		end
		if (state_q == ST_MOD_MUL) begin
			p2_q <= P1_W'(slot_q) * P1_W'(MOD_RECIP);
		end
		if (state_q == ST_MOD_FIX) begin
			m2_q <= M2_W'(q2) * M2_W'(NUM_BUCKETS);
		end
		if (state_q == ST_IDX) begin
			idx_q <= idx_d;
		end
	end

	// bucket update: tag miss restarts the bucket, a level reset wipes the ring
	always_comb begin
		rd_tag     = rd_q[MEM_W-1:RISE_W];
		rd_rise    = rd_q[RISE_W-1:0];
		hit_cur    = bvalid_q[idx_q] && (rd_tag == slot_q[TAG_W-1:0]);
		reset_now  = last_valid_q &&
			((LVL_W + 1)'(level_q) + (LVL_W + 1)'(tol_q) < (LVL_W + 1)'(last_level_q));
		if (last_valid_q && (level_q > last_level_q)) begin
			delta = level_q - last_level_q;
		end else begin
			delta = '0;
		end
		rise_sum = (RISE_W + 1)'(hit_cur ? rd_rise : '0) + (RISE_W + 1)'(delta);
		if (reset_now) begin
			rise_new = '0;
		end else if (rise_sum[RISE_W]) begin
			rise_new = '1;
		end else begin
			rise_new = rise_sum[RISE_W-1:0];
		end
		cur_onehot = NUM_BUCKETS'(1) << idx_q;
		// window of the newest NUM_BUCKETS slots, pinned to slot 0 early on
		if (slot_q >= TIME_W'(NUM_BUCKETS - 1)) begin
			first_slot = slot_q - TIME_W'(NUM_BUCKETS - 1);
			if (idx_q == IDX_W'(NUM_BUCKETS - 1)) begin
				first_ptr = '0;
			end else begin
				first_ptr = idx_q + IDX_W'(1);
			end
		end else begin
			first_slot = '0;
			first_ptr  = '0;
		end
	end

	// bucket memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (state_q == ST_RMW) begin
			mem[idx_q] <= {slot_q[TAG_W-1:0], rise_new};
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bvalid_q     <= '0;
			last_level_q <= '0;
			last_valid_q <= 1'b0;
			samples_q    <= '0;
			reset_seen_q <= 1'b0;
		end else if (state_q == ST_RMW) begin
			last_level_q <= level_q;
			last_valid_q <= 1'b1;
			reset_seen_q <= reset_now;
			if (reset_now) begin
				bvalid_q  <= cur_onehot;
				samples_q <= CNT_W'(1);
			end else begin
				bvalid_q <= bvalid_q | cur_onehot;
				if (samples_q != '1) begin
					samples_q <= samples_q + CNT_W'(1);
				end
			end
		end
	end

	// window walk: issue a read per bucket, score it in the next cycle
	always_comb begin
		walk_hit  = act_s1 && vld_s1 && (rd_q[MEM_W-1:RISE_W] == want_tag_s1);
		total_sum = (TOTAL_W + 1)'(total_q) + (TOTAL_W + 1)'(rd_q[RISE_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s1 <= 1'b0;
		end else begin
			act_s1 <= (state_q == ST_WALK) && (pos_q < POS_W'(NUM_BUCKETS));
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RMW) begin
			pos_q   <= '0;
			ptr_q   <= first_ptr;
			want_q  <= first_slot;
			mask_q  <= '0;
			total_q <= '0;
			hits_q  <= '0;
			for (int i = 0; i < REPORTED; i++) begin
				rises_q[i] <= '0;
			end
		end else if (state_q == ST_WALK) begin
			if (pos_q < POS_W'(NUM_BUCKETS)) begin
				pos_q  <= pos_q + POS_W'(1);
				want_q <= want_q + TIME_W'(1);
				if (ptr_q == IDX_W'(NUM_BUCKETS - 1)) begin
					ptr_q <= '0;
				end else begin
					ptr_q <= ptr_q + IDX_W'(1);
				end
			end
			if (walk_hit) begin
				hits_q <= hits_q + HIT_W'(1);
				if (total_sum[TOTAL_W]) begin
					total_q <= '1;
				end else begin
					total_q <= total_sum[TOTAL_W-1:0];
				end
				if (pos_s1 < POS_W'(REPORTED)) begin
					mask_q[pos_s1[RPT_W-1:0]]  <= 1'b1;
					rises_q[pos_s1[RPT_W-1:0]] <= rd_q[RISE_W-1:0];
				end
			end
		end
		vld_s1      <= bvalid_q[ptr_q];
		want_tag_s1 <= want_q[TAG_W-1:0];
		pos_s1      <= pos_q;
	end

	// report assembly
	always_comb begin
		if (early_q) begin
			status_d = early_code_q;
		end else if (reset_seen_q) begin
			status_d = SC_RESET_SEEN;
		end else if (samples_q >= CNT_W'(2)) begin
			status_d = (hits_q == HIT_W'(NUM_BUCKETS)) ? SC_ONLINE_FULL : SC_ONLINE_PART;
		end else begin
			status_d = SC_BASELINE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (report.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q <= status_d;
			if (early_q) begin
				is_ready_q <= 1'b0;
				seen_q     <= '0;
				omask_q    <= '0;
				ototal_q   <= '0;
				for (int i = 0; i < REPORTED; i++) begin
					orise_q[i] <= '0;
				end
			end else begin
				is_ready_q <= (samples_q >= CNT_W'(2));
				seen_q     <= samples_q;
				omask_q    <= mask_q;
				ototal_q   <= total_q;
				for (int i = 0; i < REPORTED; i++) begin
					orise_q[i] <= rises_q[i];
				end
			end
		end
	end

	assign report.valid        = out_valid_q;
	assign report.status_code  = status_q;
	assign report.is_ready     = is_ready_q;
	assign report.samples_seen = seen_q;
	assign report.bucket_mask  = omask_q;
	assign report.window_total = ototal_q;
	assign report.rise_0       = orise_q[0];
	assign report.rise_1       = orise_q[1];
	assign report.rise_2       = orise_q[2];
	assign report.rise_3       = orise_q[3];
	assign report.rise_4       = orise_q[4];
	assign report.rise_5       = orise_q[5];

endmodule

// File: tb/tb_top.sv
// self-checking testbench for windowed_usage_rise_tracker_unit: a scoreboard class
// mirrors the bucket ring and checks every report; tasks drive samples and apb writes
// depends on wurt_pkg and the channel interfaces in hdl/wurt_channels.sv

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import wurt_pkg::*;

	localparam int unsigned TAG_MASK   = (1 << TAG_W) - 1;
	localparam int unsigned RISE_MAX   = (1 << RISE_W) - 1;
	localparam int unsigned COUNT_MAX  = (1 << CNT_W) - 1;
	localparam int unsigned TOTAL_MAX  = (1 << TOTAL_W) - 1;
	localparam int          LEVEL_MAX  = (1 << LVL_W) - 1;
	localparam int          FULL_CYCLES = 9 + NUM_BUCKETS;
	// quiet time after the last report before a register write or the end
	localparam int          SETTLE_CYCLES = FULL_CYCLES + 10;

	// one report as seen on the output channel
	typedef struct {
		status_t             status;
		logic                is_ready;
		logic [CNT_W-1:0]    samples;
		logic [REPORTED-1:0] mask;
		logic [TOTAL_W-1:0]  total;
		logic [RISE_W-1:0]   rise [REPORTED];
	} report_t;

	// mirror of the tracker: registers, bucket ring, level history, sample count
	class report_scoreboard;
		int unsigned min_valid;
		int unsigned tolerance;
		int unsigned ring_tag  [NUM_BUCKETS];
		int unsigned ring_rise [NUM_BUCKETS];
		bit          ring_live [NUM_BUCKETS];
		int unsigned prev_level;
		bit          prev_known;
		int unsigned count;
		report_t     awaited [$];
		int unsigned failures;

		function new();
			min_valid  = MIN_VALID_RESET;
			tolerance  = TOL_RESET;
			prev_level = 0;
			prev_known = 0;
			count      = 0;
			failures   = 0;
			clear_ring();
		endfunction

		function void clear_ring();
			for (int i = 0; i < NUM_BUCKETS; i++) begin
				ring_tag[i]  = 0;
				ring_rise[i] = 0;
				ring_live[i] = 0;
			end
		endfunction

		function logic [31:0] register_value(cfg_reg_t sel);
			return (sel == REG_MIN_VALID_TIME) ? min_valid : tolerance;
		endfunction

		function void set_register(cfg_reg_t sel, logic [31:0] value);
			if (sel == REG_MIN_VALID_TIME)
				min_valid = value;
			else
				tolerance = value & ((1 << TOL_W) - 1);
		endfunction

		function int outstanding();
			return awaited.size();
		endfunction

		// works out the report for one accepted sample and queues it
		function void note_sample(logic [TIME_W-1:0] now, logic [LEVEL_W-1:0] level);
			report_t     r;
			int unsigned now_u, slot, tag, idx, lvl, first, wanted, j, hits, sum, grown;
			bit          dropped;
			r.status   = SC_CLOCK_WAIT;
			r.is_ready = 0;
			r.samples  = 0;
			r.mask     = 0;
			r.total    = 0;
			foreach (r.rise[i])
				r.rise[i] = 0;
			now_u = now;
			if (now_u < min_valid) begin
				awaited.push_back(r);
				return;
			end
			if (level[LEVEL_W-1]) begin
				r.status = SC_LEVEL_MISSING;
				awaited.push_back(r);
				return;
			end
			lvl  = 32'(level[LVL_W-1:0]);
			slot = now_u / SLOT_SECONDS;
			tag  = slot & TAG_MASK;
			idx  = slot % NUM_BUCKETS;
			// a stale or empty bucket is retagged for the current slot
			if (!ring_live[idx] || ring_tag[idx] != tag) begin
				ring_tag[idx]  = tag;
				ring_rise[idx] = 0;
				ring_live[idx] = 1;
			end
			dropped = prev_known && (lvl + tolerance < prev_level);
			if (dropped) begin
				clear_ring();
				count          = 1;
				ring_tag[idx]  = tag;
				ring_live[idx] = 1;
			end else begin
				if (count < COUNT_MAX)
					count++;
				if (prev_known && lvl > prev_level) begin
					grown = ring_rise[idx] + (lvl - prev_level);
					ring_rise[idx] = (grown > RISE_MAX) ? RISE_MAX : grown;
				end
			end
			prev_level = lvl;
			prev_known = 1;

			// window of the most recent slots, oldest first, pinned at slot 0 early on
			first = (slot >= NUM_BUCKETS - 1) ? slot - (NUM_BUCKETS - 1) : 0;
			hits  = 0;
			sum   = 0;
			for (int i = 0; i < NUM_BUCKETS; i++) begin
				wanted = first + i;
				j      = wanted % NUM_BUCKETS;
				if (ring_live[j] && ring_tag[j] == (wanted & TAG_MASK)) begin
					sum += ring_rise[j];
					if (sum > TOTAL_MAX)
						sum = TOTAL_MAX;
					hits++;
					if (i < REPORTED) begin
						r.mask[i] = 1'b1;
						r.rise[i] = RISE_W'(ring_rise[j]);
					end
				end
			end

			if (dropped)
				r.status = SC_RESET_SEEN;
			else if (count >= 2)
				r.status = (hits == NUM_BUCKETS) ? SC_ONLINE_FULL : SC_ONLINE_PART;
			else
				r.status = SC_BASELINE;
			r.is_ready = (count >= 2);
			r.samples  = CNT_W'(count);
			r.total    = TOTAL_W'(sum);
			awaited.push_back(r);
		endfunction

		function bit field_differs(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
				return 1;
			end
			return 0;
		endfunction

		// compares one report with the oldest queued one
		function void check_report(report_t got);
			report_t want;
			bit      bad;
			if (awaited.size() == 0) begin
				$display("%0t: report with no sample pending, status %0d samples %0d total %0d",
					$time, got.status, got.samples, got.total);
				failures++;
				return;
			end
			want = awaited.pop_front();
			bad  = field_differs("status_code", 32'(want.status), 32'(got.status));
			bad |= field_differs("is_ready", 32'(want.is_ready), 32'(got.is_ready));
			bad |= field_differs("samples_seen", 32'(want.samples), 32'(got.samples));
			bad |= field_differs("bucket_mask", 32'(want.mask), 32'(got.mask));
			bad |= field_differs("window_total", 32'(want.total), 32'(got.total));
			for (int i = 0; i < REPORTED; i++)
				bad |= field_differs($sformatf("rise_%0d", i), 32'(want.rise[i]),
					32'(got.rise[i]));
			if (bad)
				failures++;
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	wurt_sample_if sample_ch ();
	wurt_report_if report_ch ();

	windowed_usage_rise_tracker_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.sample  (sample_ch),
		.report  (report_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	report_scoreboard board = new();

	// idle percentages for the sample sender and the report taker
	int unsigned send_idle_pct;
	int unsigned take_idle_pct;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// hard stop well past the slowest legal run
	initial begin
		#20_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_idle(int unsigned pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) == 0)
			return $urandom_range(60, 10);
		return $urandom_range(3, 1);
	endfunction

	// report taker: ready drops for random stretches
	initial begin : report_taker
		int unsigned stall_left;
		stall_left = 0;
		report_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left != 0) begin
				report_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				stall_left = pick_idle(take_idle_pct);
				report_ch.ready <= (stall_left == 0);
				if (stall_left != 0)
					stall_left--;
			end
		end
	end

	// every report transfer goes to the scoreboard; values read here are pre-edge
	always @(posedge clk) begin : report_monitor
		report_t got;
		if (arst_n && report_ch.valid && report_ch.ready) begin
			got.status   = status_t'(report_ch.status_code);
			got.is_ready = report_ch.is_ready;
			got.samples  = report_ch.samples_seen;
			got.mask     = report_ch.bucket_mask;
			got.total    = report_ch.window_total;
			got.rise[0]  = report_ch.rise_0;
			got.rise[1]  = report_ch.rise_1;
			got.rise[2]  = report_ch.rise_2;
			got.rise[3]  = report_ch.rise_3;
			got.rise[4]  = report_ch.rise_4;
			got.rise[5]  = report_ch.rise_5;
			board.check_report(got);
		end
	end

	// one sample transfer; valid stays up when no gap follows
	task automatic send_sample(input logic [TIME_W-1:0] now, input logic [LEVEL_W-1:0] level);
		int unsigned gap;
		sample_ch.valid       <= 1'b1;
		sample_ch.now_seconds <= now;
		sample_ch.level_used  <= level;
		do @(posedge clk); while (!sample_ch.ready);
		board.note_sample(now, level);
		gap = pick_idle(send_idle_pct);
		if (gap != 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// apb read of one register, compared with the mirrored value; the bus is left idle before the task returns
	task automatic check_register(input cfg_reg_t sel);
		logic [31:0] seen;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {sel, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		seen = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if (seen !== board.register_value(sel)) begin
			$display("%0t: register %s expected %0d actual %0d", $time, sel.name(),
				board.register_value(sel), seen);
			board.failures++;
		end
		@(posedge clk);
	endtask

	task automatic write_register(input cfg_reg_t sel, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.set_register(sel, value);
		check_register(sel);
	endtask

	// sender holds off until every queued report has come back, then a margin
	task automatic settle();
		sample_ch.valid <= 1'b0;
		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [31:0] min_time, input logic [31:0] tol);
		settle();
		write_register(REG_MIN_VALID_TIME, min_time);
		write_register(REG_RESET_TOLERANCE, tol);
	endtask

	// random samples: mostly a plausible meter walking forward in time, plus
	// level resets, missing levels, unset clocks and pure noise
	task automatic run_random(input int unsigned items);
		longint unsigned t;
		int              lvl;
		int unsigned     tol, pick, step;
		logic [31:0]     min_t;
		min_t = board.min_valid;
		tol   = board.tolerance;
		t     = longint'(min_t) + $urandom_range(0, 5000);
		if (t > 64'hFFFF_FFFF)
			t = 64'hFFFF_FFFF;
		lvl = $urandom_range(0, LEVEL_MAX);
		repeat (items) begin
			pick = $urandom_range(99);
			if (pick < 78) begin
				step = $urandom_range(99);
				if (step < 60)
					t += $urandom_range(0, 120);
				else if (step < 90)
					t += $urandom_range(121, 900);
				else
					t += $urandom_range(901, 4000);
				if (t > 64'hFFFF_FFFF)
					t = min_t;
				step = $urandom_range(99);
				if (step < 70)
					lvl += $urandom_range(0, 40);
				else if (step < 85)
					lvl += $urandom_range(41, 3000);
				else
					lvl -= int'($urandom_range(0, tol));
				if (lvl < 0)
					lvl = 0;
				if (lvl > LEVEL_MAX)
					lvl = LEVEL_MAX;
				send_sample(t[31:0], LEVEL_W'(lvl));
			end else if (pick < 86) begin
				// drop past the tolerance, or a jump to the top when no drop fits
				if (lvl > tol)
					lvl = $urandom_range(0, lvl - tol - 1);
				else
					lvl = LEVEL_MAX;
				send_sample(t[31:0], LEVEL_W'(lvl));
			end else if (pick < 91) begin
				send_sample(t[31:0], {1'b1, LVL_W'($urandom)});
			end else if (pick < 95) begin
				send_sample((min_t == 0) ? $urandom : $urandom_range(0, min_t - 1),
					LEVEL_W'($urandom));
			end else begin
				send_sample($urandom, LEVEL_W'($urandom));
			end
		end
	endtask

	initial begin : main_sequence
		logic [31:0]  phase_min  [6];
		logic [31:0]  phase_tol  [6];
		int unsigned  phase_send [6];
		int unsigned  phase_take [6];
		logic [31:0]  burst_time;

		arst_n                <= 1'b0;
		psel                  <= 1'b0;
		penable               <= 1'b0;
		pwrite                <= 1'b0;
		paddr                 <= '0;
		pwdata                <= '0;
		sample_ch.valid       <= 1'b0;
		sample_ch.now_seconds <= '0;
		sample_ch.level_used  <= '0;
		send_idle_pct = 30;
		take_idle_pct = 30;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers must come out of reset with their documented values
		check_register(REG_MIN_VALID_TIME);
		check_register(REG_RESET_TOLERANCE);

		// directed: clock not set, at zero time and just under the threshold
		send_sample(32'd0, LEVEL_W'(100));
		send_sample(32'd1699999999, LEVEL_W'(LEVEL_MAX));
		// level missing, all ones and the most negative value
		send_sample(32'd1700000000, LEVEL_W'(-1));
		send_sample(32'd1700000000, LEVEL_W'(-16384));
		// baseline, then rises in the same slot up to the top level
		send_sample(32'd1700000000, LEVEL_W'(0));
		send_sample(32'd1700000000, LEVEL_W'(200));
		send_sample(32'd1700000050, LEVEL_W'(LEVEL_MAX));
		// a drop equal to the tolerance is not a reset, one more is
		send_sample(32'd1700000060, LEVEL_W'(LEVEL_MAX - 5));
		send_sample(32'd1700000070, LEVEL_W'(LEVEL_MAX - 11));
		// one sample per slot until the whole window is populated
		for (int k = 0; k < NUM_BUCKETS; k++)
			send_sample(32'd1700000100 + 300 * k, LEVEL_W'(LEVEL_MAX - 10 + k));
		// skip far ahead so every bucket goes stale
		send_sample(32'd1700004000, LEVEL_W'(LEVEL_MAX - 3));
		// clock wait with history in place must not disturb it
		send_sample(32'd5, LEVEL_W'(100));
		// top of the time range
		send_sample(32'hFFFF_FFFF, LEVEL_W'(0));
		send_sample(32'hFFFF_FFFF, LEVEL_W'(LEVEL_MAX));

		// early window: slots below the ring size start the window at slot 0
		configure(32'd0, 32'd5);
		send_sample(32'd0, LEVEL_W'(0));
		send_sample(32'd299, LEVEL_W'(10));
		send_sample(32'd300, LEVEL_W'(20));
		send_sample(32'd1200, LEVEL_W'(40));
		send_sample(32'd1500, LEVEL_W'(50));
		send_sample(32'd1800, LEVEL_W'(60));

		// bucket saturation: swing within the tolerance inside one slot until the
		// accumulated rise passes the bucket limit
		configure(32'd0, 32'd1000);
		burst_time = 32'd1800000000;
		send_sample(burst_time, LEVEL_W'(14000));
		repeat (70) begin
			send_sample(burst_time, LEVEL_W'(15000));
			send_sample(burst_time, LEVEL_W'(14000));
		end

		// random phases over several register settings, the extremes among them;
		// the tolerance write of all ones checks masking to the register width
		phase_min[0] = MIN_VALID_RESET;   phase_tol[0] = TOL_RESET;
		phase_min[1] = 32'd0;             phase_tol[1] = 32'd0;
		phase_min[2] = 32'hFFFF_FFFF;     phase_tol[2] = 32'hFFFF_FFFF;
		phase_min[3] = $urandom;          phase_tol[3] = 32'd1000;
		phase_min[4] = 32'h8000_0000;     phase_tol[4] = $urandom_range(0, 1023);
		phase_min[5] = 32'd1700000000 + $urandom_range(0, 1000000);
		phase_tol[5] = $urandom_range(0, 63);
		phase_send[0] = 0;  phase_take[0] = 0;
		phase_send[1] = 30; phase_take[1] = 30;
		phase_send[2] = 50; phase_take[2] = 50;
		phase_send[3] = 20; phase_take[3] = 60;
		phase_send[4] = 70; phase_take[4] = 10;
		phase_send[5] = 10; phase_take[5] = 40;
		for (int p = 0; p < 6; p++) begin
			configure(phase_min[p], phase_tol[p]);
			send_idle_pct = phase_send[p];
			take_idle_pct = phase_take[p];
			run_random(125);
		end

		settle();
		if (board.failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: windowed_usage_rise_tracker_unit.f
hdl/wurt_pkg.sv
hdl/wurt_channels.sv
hdl/windowed_usage_rise_tracker_unit.sv
tb/tb_top.sv
